// ===== rtl/core/arcade_bus_decoder_with_video_rams_macros.svh =====
// assertion macros shared by the core
`ifndef ARCADE_BUS_DECODER_WITH_VIDEO_RAMS_MACROS_SVH
`define ARCADE_BUS_DECODER_WITH_VIDEO_RAMS_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define ABD_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// property that must hold in the cycle after its trigger
`define ABD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/core/arcbus_pkg.sv =====
package arcbus_pkg;

  // request kinds
  typedef enum logic [2:0] {
    KIND_MEM_RD  = 3'd0,
    KIND_MEM_WR  = 3'd1,
    KIND_IO_RD   = 3'd2,
    KIND_IO_WR   = 3'd3,
    KIND_PAL_LKP = 3'd4
  } kind_t;

  // forwarding targets
  typedef enum logic [2:0] {
    FWD_NONE  = 3'd0,
    FWD_PPI   = 3'd1,
    FWD_SOUND = 3'd2,
    FWD_IRQ   = 3'd3,
    FWD_ROM   = 3'd4
  } fwd_t;

  // source of the read byte or colour in the result stage
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_WORK,
    SRC_BG,
    SRC_DIPA,
    SRC_DIPB,
    SRC_PAL
  } src_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PROT  = 2'd0,
    REG_DIP_A = 2'd1,
    REG_DIP_B = 2'd2
  } reg_idx_t;

  localparam logic [11:0] PROT_RESET  = 12'd3622;
  localparam logic [7:0]  DIP_A_RESET = 8'd255;
  localparam logic [7:0]  DIP_B_RESET = 8'd254;
  localparam logic [11:0] PROT_BELOW  = 12'ha;
  localparam logic [11:0] PROT_ABOVE  = 12'h1;

  localparam logic [3:0]  WORK_PAGE   = 4'hf;
  localparam logic [16:0] ROM_IO_BIAS = 17'h08000;

  localparam logic [15:0] PAL_LO_BASE = 16'h2000;
  localparam logic [15:0] PAL_HI_BASE = 16'h2800;
  localparam logic [15:0] PAL_MASK    = 16'hfc00;
  localparam logic [15:0] SCROLL_BASE = 16'h6000;
  localparam logic [15:0] SCROLL_MASK = 16'hffc0;
  localparam logic [15:0] FG_BASE     = 16'h6800;
  localparam logic [15:0] FG_MASK     = 16'hfe00;
  localparam logic [15:0] BG_BASE     = 16'h7000;
  localparam logic [15:0] BG_MASK     = 16'hf000;
  localparam logic [15:0] PPI_BASE    = 16'h5080;
  localparam logic [15:0] PPI_MASK    = 16'hfffc;
  localparam logic [15:0] SOUND_BASE  = 16'h50b0;
  localparam logic [15:0] SOUND_MASK  = 16'hfffe;
  localparam logic [15:0] IRQ_ADDR    = 16'h50c0;
  localparam logic [15:0] DIP_A_ADDR  = 16'h5090;
  localparam logic [15:0] DIP_B_ADDR  = 16'h50a0;

  localparam logic [4:0]  CHAN_MASK   = 5'h1f;
  localparam logic [1:0]  MIRROR_STEPS = 2'd2;

  // 5-bit colour to 8 bits, top bits copied into the low bits
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [4:0] c;
    c = v & CHAN_MASK;
    return {c, c[4:2]};
  endfunction

endpackage

// ===== rtl/core/arcade_bus_decoder_with_video_rams.sv =====
// channel   | direction | handshake            | payload
// request   | in        | req_valid/req_ready  | kind, address, data
// result    | out       | res_valid/res_ready  | read_data, forward_*, red, green, blue
// config    | in        | apb psel/penable     | paddr, pwdata, prdata
//
// one request per cycle unless stalled; results pass the decode and result registers
// a work ram write that hits the protection offset holds off requests: the two
//   mirror bytes go through the single work ram write port before the next request
// after reset a clearing pass zeroes the rams, requests held off
// res_ready low stalls the result register and then the decode stage behind it
`include "arcade_bus_decoder_with_video_rams_macros.svh"

module arcade_bus_decoder_with_video_rams (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  // result channel
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  read_data,
  output logic [2:0]  forward_target,
  output logic [16:0] forward_offset,
  output logic [7:0]  forward_data,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [11:0] protection_offset;
  logic [7:0]  dip_bank_a;
  logic [7:0]  dip_bank_b;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      protection_offset <= arcbus_pkg::PROT_RESET;
      dip_bank_a        <= arcbus_pkg::DIP_A_RESET;
      dip_bank_b        <= arcbus_pkg::DIP_B_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        arcbus_pkg::REG_PROT:  protection_offset <= pwdata[11:0];
        arcbus_pkg::REG_DIP_A: dip_bank_a        <= pwdata[7:0];
        arcbus_pkg::REG_DIP_B: dip_bank_b        <= pwdata[7:0];
        default: ;  // beyond the register list, dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      arcbus_pkg::REG_PROT:  prdata = {20'd0, protection_offset};
      arcbus_pkg::REG_DIP_A: prdata = {24'd0, dip_bank_a};
      arcbus_pkg::REG_DIP_B: prdata = {24'd0, dip_bank_b};
      default:               prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // ram clearing pass after reset
  // ------------------------------------------------------------------
  logic        clearing;
  logic [11:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= 12'd0;
    end else if (clearing) begin
      clr_idx  <= clr_idx + 12'd1;
      clearing <= (clr_idx != 12'hfff);
    end
  end

  // ------------------------------------------------------------------
  // request decode, straight from the request ports
  // ------------------------------------------------------------------
  arcbus_pkg::src_t dec_src;
  arcbus_pkg::fwd_t dec_tgt;
  logic [16:0]      dec_off;
  logic [7:0]       dec_fd;
  logic             wr_work;
  logic             wr_bg;
  logic             wr_pal_lo;
  logic             wr_pal_hi;
  logic             prot_hit;

  assign prot_hit = (address[11:0] == protection_offset);

  always_comb begin
    dec_src   = arcbus_pkg::SRC_NONE;
    dec_tgt   = arcbus_pkg::FWD_NONE;
    dec_off   = 17'd0;
    dec_fd    = 8'd0;
    wr_work   = 1'b0;
    wr_bg     = 1'b0;
    wr_pal_lo = 1'b0;
    wr_pal_hi = 1'b0;
    unique case (kind)
      arcbus_pkg::KIND_MEM_RD: begin
        if (address[15:12] == arcbus_pkg::WORK_PAGE) begin
          dec_src = arcbus_pkg::SRC_WORK;
        end else begin
          // program rom, decryption sits outside
          dec_tgt = arcbus_pkg::FWD_ROM;
          dec_off = {1'b0, address};
        end
      end
      arcbus_pkg::KIND_MEM_WR: begin
        wr_work = (address[15:12] == arcbus_pkg::WORK_PAGE);
      end
      arcbus_pkg::KIND_IO_RD: begin
        if ((address & arcbus_pkg::BG_MASK) == arcbus_pkg::BG_BASE) begin
          dec_src = arcbus_pkg::SRC_BG;
        end else if (address[15]) begin
          // upper half of i/o space reads the second rom half
          dec_tgt = arcbus_pkg::FWD_ROM;
          dec_off = {1'b0, address} + arcbus_pkg::ROM_IO_BIAS;
        end else if ((address & arcbus_pkg::PPI_MASK) == arcbus_pkg::PPI_BASE) begin
          dec_tgt = arcbus_pkg::FWD_PPI;
          dec_off = {15'd0, address[1:0]};
        end else if (address == arcbus_pkg::DIP_A_ADDR) begin
          dec_src = arcbus_pkg::SRC_DIPA;
        end else if (address == arcbus_pkg::DIP_B_ADDR) begin
          dec_src = arcbus_pkg::SRC_DIPB;
        end
      end
      arcbus_pkg::KIND_IO_WR: begin
        if ((address & arcbus_pkg::PAL_MASK) == arcbus_pkg::PAL_LO_BASE) begin
          wr_pal_lo = 1'b1;
        end else if ((address & arcbus_pkg::PAL_MASK) == arcbus_pkg::PAL_HI_BASE) begin
          wr_pal_hi = 1'b1;
        end else if ((address & arcbus_pkg::SCROLL_MASK) == arcbus_pkg::SCROLL_BASE) begin
          // column scroll, only read by the tile renderer
        end else if ((address & arcbus_pkg::FG_MASK) == arcbus_pkg::FG_BASE) begin
          // foreground ram, only read by the tile renderer
        end else if ((address & arcbus_pkg::BG_MASK) == arcbus_pkg::BG_BASE) begin
          wr_bg = 1'b1;
        end else if ((address & arcbus_pkg::PPI_MASK) == arcbus_pkg::PPI_BASE) begin
          dec_tgt = arcbus_pkg::FWD_PPI;
          dec_off = {15'd0, address[1:0]};
          dec_fd  = data;
        end else if ((address & arcbus_pkg::SOUND_MASK) == arcbus_pkg::SOUND_BASE) begin
          dec_tgt = arcbus_pkg::FWD_SOUND;
          dec_off = {16'd0, address[0]};
          dec_fd  = data;
        end else if (address == arcbus_pkg::IRQ_ADDR) begin
          dec_tgt = arcbus_pkg::FWD_IRQ;
        end
      end
      arcbus_pkg::KIND_PAL_LKP: begin
        dec_src = arcbus_pkg::SRC_PAL;
      end
      default: ;  // unused kinds give an all-zero result
    endcase
  end

  // ------------------------------------------------------------------
  // pipeline control
  // ------------------------------------------------------------------
  logic             s1_valid;
  arcbus_pkg::src_t s1_src;
  arcbus_pkg::fwd_t s1_tgt;
  logic [16:0]      s1_off;
  logic [7:0]       s1_fd;
  logic             s1_move;
  logic             req_fire;
  logic [1:0]       mirror_cnt;
  logic [11:0]      mirror_base;
  logic [7:0]       mirror_data;

  assign s1_move   = s1_valid & (~res_valid | res_ready);
  assign req_ready = ~clearing & (mirror_cnt == 2'd0) & (~s1_valid | s1_move);
  assign req_fire  = req_valid & req_ready;

  // ------------------------------------------------------------------
  // protection mirror: two extra work ram writes after the hit
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_cnt <= 2'd0;
    end else if (req_fire && wr_work && prot_hit) begin
      mirror_cnt <= arcbus_pkg::MIRROR_STEPS;
    end else if (mirror_cnt != 2'd0) begin
      mirror_cnt <= mirror_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      mirror_base <= address[11:0];
      mirror_data <= data;
    end
  end

  // ------------------------------------------------------------------
  // rams, accessed at the acceptance edge
  // ------------------------------------------------------------------
  logic [7:0]  work_ram [4096];
  logic [7:0]  background_ram [4096];
  logic [7:0]  palette_lo [1024];
  logic [7:0]  palette_hi [1024];
  logic [7:0]  work_q;
  logic [7:0]  bg_q;
  logic [7:0]  pal_lo_q;
  logic [7:0]  pal_hi_q;

  logic        work_we;
  logic [11:0] work_waddr;
  logic [7:0]  work_wdata;
  logic        bg_we;
  logic [11:0] bg_waddr;
  logic        pal_lo_we;
  logic        pal_hi_we;
  logic [9:0]  pal_waddr;
  logic [7:0]  fill_data;

  assign fill_data = clearing ? 8'd0 : data;

  always_comb begin
    work_we    = 1'b1;
    work_waddr = address[11:0];
    work_wdata = data;
    if (clearing) begin
      work_waddr = clr_idx;
      work_wdata = 8'd0;
    end else if (mirror_cnt == arcbus_pkg::MIRROR_STEPS) begin
      work_waddr = mirror_base - arcbus_pkg::PROT_BELOW;
      work_wdata = mirror_data;
    end else if (mirror_cnt != 2'd0) begin
      work_waddr = mirror_base + arcbus_pkg::PROT_ABOVE;
      work_wdata = mirror_data;
    end else begin
      work_we = req_fire & wr_work;
    end
  end

  assign bg_we     = clearing | (req_fire & wr_bg);
  assign bg_waddr  = clearing ? clr_idx : address[11:0];
  assign pal_lo_we = clearing | (req_fire & wr_pal_lo);
  assign pal_hi_we = clearing | (req_fire & wr_pal_hi);
  assign pal_waddr = clearing ? clr_idx[9:0] : address[9:0];

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_ram[work_waddr] <= work_wdata;
    end
    if (req_fire && dec_src == arcbus_pkg::SRC_WORK) begin
      work_q <= work_ram[address[11:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (bg_we) begin
      background_ram[bg_waddr] <= fill_data;
    end
    if (req_fire && dec_src == arcbus_pkg::SRC_BG) begin
      bg_q <= background_ram[address[11:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_lo_we) begin
      palette_lo[pal_waddr] <= fill_data;
    end
    if (req_fire && dec_src == arcbus_pkg::SRC_PAL) begin
      pal_lo_q <= palette_lo[address[9:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pal_hi_we) begin
      palette_hi[pal_waddr] <= fill_data;
    end
    if (req_fire && dec_src == arcbus_pkg::SRC_PAL) begin
      pal_hi_q <= palette_hi[address[9:0]];
    end
  end

  // ------------------------------------------------------------------
  // decode stage register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_src <= dec_src;
      s1_tgt <= dec_tgt;
      s1_off <= dec_off;
      s1_fd  <= dec_fd;
    end
  end

  // ------------------------------------------------------------------
  // result formation and result register
  // ------------------------------------------------------------------
  logic [7:0]  read_data_next;
  logic [7:0]  red_next;
  logic [7:0]  green_next;
  logic [7:0]  blue_next;
  logic [15:0] pal_word;

  assign pal_word = {pal_hi_q, pal_lo_q};

  always_comb begin
    read_data_next = 8'd0;
    red_next       = 8'd0;
    green_next     = 8'd0;
    blue_next      = 8'd0;
    case (s1_src)
      arcbus_pkg::SRC_WORK: read_data_next = work_q;
      arcbus_pkg::SRC_BG:   read_data_next = bg_q;
      arcbus_pkg::SRC_DIPA: read_data_next = dip_bank_a;
      arcbus_pkg::SRC_DIPB: read_data_next = dip_bank_b;
      arcbus_pkg::SRC_PAL: begin
        // rgb555, red in the low bits
        red_next   = arcbus_pkg::expand5(pal_word[4:0]);
        green_next = arcbus_pkg::expand5(pal_word[9:5]);
        blue_next  = arcbus_pkg::expand5(pal_word[14:10]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      read_data      <= read_data_next;
      forward_target <= s1_tgt;
      forward_offset <= s1_off;
      forward_data   <= s1_fd;
      red            <= red_next;
      green          <= green_next;
      blue           <= blue_next;
    end
  end

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  `ABD_ASSERT_NOW(a_no_req_in_clear, clearing, !req_ready, "request taken during ram clear")
  `ABD_ASSERT_NOW(a_no_req_in_mirror, mirror_cnt != 2'd0, !req_ready, "request taken during mirror")
  `ABD_ASSERT_NEXT(a_mirror_start, req_fire && wr_work && prot_hit, mirror_cnt == arcbus_pkg::MIRROR_STEPS, "protection hit did not start mirror")
  `ABD_ASSERT_NOW(a_fwd_no_read, res_valid && forward_target != arcbus_pkg::FWD_NONE, read_data == 8'd0, "forwarded request carries read data")

endmodule

// ===== test/arcade_bus_decoder_with_video_rams_test.sv =====
`timescale 1ns / 1ps

module arcade_bus_decoder_with_video_rams_test;

  // cycles with no request, result or register access before the run is abandoned;
  // covers the ram clearing pass after reset with a wide margin
  localparam int QUIET_LIMIT = 12000;
  localparam int REPORT_LIMIT = 10;

  logic        clk;
  logic        rst;

  // configuration port
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // request channel
  logic        bus_valid;
  logic        bus_ready;
  logic [2:0]  bus_kind;
  logic [15:0] bus_address;
  logic [7:0]  bus_data;

  // result channel
  logic        res_valid;
  logic        res_ready;
  logic [7:0]  read_data;
  logic [2:0]  forward_target;
  logic [16:0] forward_offset;
  logic [7:0]  forward_data;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  // one expected result per accepted request
  typedef struct {
    logic [7:0]       read_byte;
    arcbus_pkg::fwd_t target;
    logic [16:0]      offset;
    logic [7:0]       fwd_byte;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } bus_outcome_t;

  bus_outcome_t outcome_q[$];

  // shadow copy of the board state; column scroll and foreground writes never
  // show on any output, so no copy of those stores is kept
  logic [7:0]  work_mem [4096];
  logic [7:0]  pal_mem  [2048];
  logic [7:0]  bg_mem   [4096];
  logic [11:0] prot_cfg;
  logic [7:0]  dip_a_cfg;
  logic [7:0]  dip_b_cfg;

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  arcade_bus_decoder_with_video_rams dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .req_valid      (bus_valid),
    .req_ready      (bus_ready),
    .kind           (bus_kind),
    .address        (bus_address),
    .data           (bus_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .read_data      (read_data),
    .forward_target (forward_target),
    .forward_offset (forward_offset),
    .forward_data   (forward_data),
    .red            (red),
    .green          (green),
    .blue           (blue)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // every input known from time zero
  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    bus_valid   = 1'b0;
    bus_kind    = '0;
    bus_address = '0;
    bus_data    = '0;
    res_ready   = 1'b0;
  end

  // 5-bit channel widened to 8 bits by repeating its top bits
  function automatic logic [7:0] colour_widen(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // expected result of one request, updating the shadow state as the board would
  function automatic bus_outcome_t decode_access(input logic [2:0] k, input logic [15:0] a,
                                                 input logic [7:0] d);
    bus_outcome_t o;
    logic [11:0]  w;
    logic [9:0]   e;
    logic [15:0]  colour;
    o.read_byte = 8'h00;
    o.target    = arcbus_pkg::FWD_NONE;
    o.offset    = '0;
    o.fwd_byte  = 8'h00;
    o.red       = 8'h00;
    o.green     = 8'h00;
    o.blue      = 8'h00;
    case (k)
      arcbus_pkg::KIND_MEM_RD: begin
        // work ram sits in the top page, everything below is rom
        if (a[15:12] == 4'hf) o.read_byte = work_mem[a[11:0]];
        else begin
          o.target = arcbus_pkg::FWD_ROM;
          o.offset = {1'b0, a};
        end
      end
      arcbus_pkg::KIND_MEM_WR: begin
        // rom writes fall through with no effect
        if (a[15:12] == 4'hf) begin
          w = a[11:0];
          work_mem[w] = d;
          // protection byte is mirrored 10 below and 1 above, wrapping in 12 bits
          if (w == prot_cfg) begin
            work_mem[12'(w - 12'd10)] = d;
            work_mem[12'(w + 12'd1)]  = d;
          end
        end
      end
      arcbus_pkg::KIND_IO_RD: begin
        if ((a & 16'hf000) == 16'h7000) o.read_byte = bg_mem[a[11:0]];
        else if (a >= 16'h8000) begin
          o.target = arcbus_pkg::FWD_ROM;
          o.offset = {1'b0, a} + 17'h08000;
        end else if ((a & 16'hfffc) == 16'h5080) begin
          o.target = arcbus_pkg::FWD_PPI;
          o.offset = {15'd0, a[1:0]};
        end else if (a == 16'h5090) o.read_byte = dip_a_cfg;
        else if (a == 16'h50a0) o.read_byte = dip_b_cfg;
      end
      arcbus_pkg::KIND_IO_WR: begin
        if ((a & 16'hfc00) == 16'h2000) pal_mem[{1'b0, a[9:0]}] = d;
        else if ((a & 16'hfc00) == 16'h2800) pal_mem[{1'b1, a[9:0]}] = d;
        else if ((a & 16'hffc0) == 16'h6000) ;
        else if ((a & 16'hfe00) == 16'h6800) ;
        else if ((a & 16'hf000) == 16'h7000) bg_mem[a[11:0]] = d;
        else if ((a & 16'hfffc) == 16'h5080) begin
          o.target   = arcbus_pkg::FWD_PPI;
          o.offset   = {15'd0, a[1:0]};
          o.fwd_byte = d;
        end else if ((a & 16'hfffe) == 16'h50b0) begin
          o.target   = arcbus_pkg::FWD_SOUND;
          o.offset   = {16'd0, a[0]};
          o.fwd_byte = d;
        end else if (a == 16'h50c0) o.target = arcbus_pkg::FWD_IRQ;
      end
      arcbus_pkg::KIND_PAL_LKP: begin
        // low bank holds the low byte of the rgb555 entry, high bank the high byte
        e      = a[9:0];
        colour = {pal_mem[{1'b1, e}], pal_mem[{1'b0, e}]};
        o.red   = colour_widen(colour[4:0]);
        o.green = colour_widen(colour[9:5]);
        o.blue  = colour_widen(colour[14:10]);
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // one request: optional idle cycles, then hold valid until accepted
  task automatic send_request(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d);
    while (($urandom % 100) < send_idle_pct) begin
      @(negedge clk);
      bus_valid = 1'b0;
    end
    @(negedge clk);
    bus_valid   = 1'b1;
    bus_kind    = k;
    bus_address = a;
    bus_data    = d;
    do @(posedge clk); while (!bus_ready);
    outcome_q.push_back(decode_access(k, a, d));
  endtask

  // stop sending and wait for every outstanding result, plus the tail of a mirror write
  task automatic drain_requests();
    @(negedge clk);
    bus_valid = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_register(input arcbus_pkg::reg_idx_t idx, output logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // register write followed by a read back against the shadow copy
  task automatic write_register(input arcbus_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] back;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      arcbus_pkg::REG_PROT:  prot_cfg  = value[11:0];
      arcbus_pkg::REG_DIP_A: dip_a_cfg = value[7:0];
      arcbus_pkg::REG_DIP_B: dip_b_cfg = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    read_register(idx, back);
    case (idx)
      arcbus_pkg::REG_PROT:  check_field("protection_offset", {20'd0, prot_cfg}, back);
      arcbus_pkg::REG_DIP_A: check_field("dip_bank_a", {24'd0, dip_a_cfg}, back);
      arcbus_pkg::REG_DIP_B: check_field("dip_bank_b", {24'd0, dip_b_cfg}, back);
      default: ;
    endcase
  endtask

  // work ram offsets cluster around the protection byte so mirrors get read back
  function automatic logic [11:0] pick_work_offset();
    case ($urandom_range(0, 3))
      0, 1:    return 12'(prot_cfg - 12'd11 + 12'($urandom_range(0, 13)));
      2:       return 12'($urandom_range(0, 15));
      default: return 12'($urandom);
    endcase
  endfunction

  // palette entries from a small pool at both ends, so lookups see earlier writes
  function automatic logic [9:0] pick_entry();
    case ($urandom_range(0, 3))
      0, 1:    return 10'($urandom_range(0, 7));
      2:       return 10'($urandom_range(1016, 1023));
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_bg_offset();
    if ($urandom_range(0, 2) != 0) return 12'($urandom_range(0, 15));
    return 12'($urandom);
  endfunction

  // one random request, weighted towards ram traffic that is read back later
  task automatic random_request();
    int          sel;
    logic [2:0]  k;
    logic [15:0] a;
    logic [7:0]  d;
    sel = $urandom_range(0, 99);
    d   = 8'($urandom);
    k   = arcbus_pkg::KIND_IO_WR;
    a   = 16'($urandom);
    if (sel < 20) begin
      k = arcbus_pkg::KIND_MEM_WR;
      a = {4'hf, pick_work_offset()};
    end else if (sel < 35) begin
      k = arcbus_pkg::KIND_MEM_RD;
      a = {4'hf, pick_work_offset()};
    end else if (sel < 45) begin
      k = arcbus_pkg::KIND_IO_WR;
      a = ($urandom_range(0, 1) ? 16'h2800 : 16'h2000) | {6'd0, pick_entry()};
    end else if (sel < 55) begin
      // upper address bits are don't-care for a lookup
      k = arcbus_pkg::KIND_PAL_LKP;
      a = {6'($urandom), pick_entry()};
    end else if (sel < 62) begin
      k = $urandom_range(0, 1) ? arcbus_pkg::KIND_IO_WR : arcbus_pkg::KIND_IO_RD;
      a = {4'h7, pick_bg_offset()};
    end else if (sel < 66) begin
      k = arcbus_pkg::KIND_IO_WR;
      a = $urandom_range(0, 1) ? (16'h6000 | 16'($urandom_range(0, 63)))
                               : (16'h6800 | 16'($urandom_range(0, 511)));
    end else if (sel < 76) begin
      k = arcbus_pkg::KIND_IO_RD;
      case ($urandom_range(0, 5))
        0:       a = 16'h5080 | 16'($urandom_range(0, 3));
        1:       a = 16'h5090;
        2:       a = 16'h50a0;
        3:       a = {1'b1, 15'($urandom)};
        // the chip window, near misses included
        4:       a = 16'h5080 + 16'($urandom_range(0, 16'h4f));
        default: a = 16'($urandom);
      endcase
    end else if (sel < 84) begin
      k = arcbus_pkg::KIND_IO_WR;
      case ($urandom_range(0, 3))
        0:       a = 16'h5080 | 16'($urandom_range(0, 3));
        1:       a = 16'h50b0 | 16'($urandom_range(0, 1));
        2:       a = 16'h50c0;
        default: a = 16'h5080 + 16'($urandom_range(0, 16'h4f));
      endcase
    end else if (sel < 90) begin
      // rom side of the memory map
      k = $urandom_range(0, 1) ? arcbus_pkg::KIND_MEM_WR : arcbus_pkg::KIND_MEM_RD;
      a = 16'($urandom_range(0, 16'hefff));
    end else begin
      // noise, undefined kinds included
      k = 3'($urandom_range(0, 7));
    end
    send_request(k, a, d);
  endtask

  // registers must come up at their documented reset values
  task automatic test_reset_values();
    logic [31:0] value;
    read_register(arcbus_pkg::REG_PROT, value);
    check_field("protection_offset at reset", {20'd0, prot_cfg}, value);
    read_register(arcbus_pkg::REG_DIP_A, value);
    check_field("dip_bank_a at reset", {24'd0, dip_a_cfg}, value);
    read_register(arcbus_pkg::REG_DIP_B, value);
    check_field("dip_bank_b at reset", {24'd0, dip_b_cfg}, value);
  endtask

  // hand-picked requests: map edges, every kind and every forwarding target
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // protection byte at its reset offset, then both mirrors read back
    send_request(arcbus_pkg::KIND_MEM_WR, 16'hfe26, 8'hff);
    send_request(arcbus_pkg::KIND_MEM_RD, 16'hfe1c, 8'h00);
    send_request(arcbus_pkg::KIND_MEM_RD, 16'hfe27, 8'h00);
    send_request(arcbus_pkg::KIND_MEM_WR, 16'hffff, 8'ha5);
    send_request(arcbus_pkg::KIND_MEM_RD, 16'hffff, 8'h00);
    send_request(arcbus_pkg::KIND_MEM_RD, 16'hf000, 8'h00);
    // rom reads and an ignored rom write
    send_request(arcbus_pkg::KIND_MEM_RD, 16'h0000, 8'h00);
    send_request(arcbus_pkg::KIND_MEM_RD, 16'hefff, 8'h00);
    send_request(arcbus_pkg::KIND_MEM_WR, 16'hefff, 8'h55);
    // palette at entry 0 of both banks and the top entry of the high bank
    send_request(arcbus_pkg::KIND_IO_WR, 16'h2000, 8'hff);
    send_request(arcbus_pkg::KIND_IO_WR, 16'h2800, 8'h7f);
    send_request(arcbus_pkg::KIND_PAL_LKP, 16'h0000, 8'h00);
    send_request(arcbus_pkg::KIND_IO_WR, 16'h2bff, 8'h21);
    send_request(arcbus_pkg::KIND_PAL_LKP, 16'hffff, 8'h00);
    // scroll and foreground stores, background written and read
    send_request(arcbus_pkg::KIND_IO_WR, 16'h603f, 8'h81);
    send_request(arcbus_pkg::KIND_IO_WR, 16'h69ff, 8'h18);
    send_request(arcbus_pkg::KIND_IO_WR, 16'h7fff, 8'h3c);
    send_request(arcbus_pkg::KIND_IO_RD, 16'h7fff, 8'h00);
    // io rom window, chip forwards, dips
    send_request(arcbus_pkg::KIND_IO_RD, 16'h8000, 8'h00);
    send_request(arcbus_pkg::KIND_IO_RD, 16'hffff, 8'h00);
    send_request(arcbus_pkg::KIND_IO_RD, 16'h5083, 8'h00);
    send_request(arcbus_pkg::KIND_IO_WR, 16'h5080, 8'hc3);
    send_request(arcbus_pkg::KIND_IO_WR, 16'h50b1, 8'hff);
    send_request(arcbus_pkg::KIND_IO_WR, 16'h50c0, 8'h77);
    send_request(arcbus_pkg::KIND_IO_RD, 16'h5090, 8'h00);
    send_request(arcbus_pkg::KIND_IO_RD, 16'h50a0, 8'h00);
    // unmapped io and an undefined kind
    send_request(arcbus_pkg::KIND_IO_WR, 16'h50c1, 8'h99);
    send_request(3'd7, 16'h1234, 8'hee);
  endtask

  // one traffic phase under given register settings and idling
  task automatic test_traffic(input int count, input int idle_pct, input int stall_pct,
                              input logic [11:0] prot, input logic [7:0] dip_a,
                              input logic [7:0] dip_b, input bit pause_midway);
    drain_requests();
    write_register(arcbus_pkg::REG_PROT, {20'd0, prot});
    write_register(arcbus_pkg::REG_DIP_A, {24'd0, dip_a});
    write_register(arcbus_pkg::REG_DIP_B, {24'd0, dip_b});
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // sender holds off until the pipe has run dry
      if (pause_midway && i == count / 2) drain_requests();
      random_request();
    end
  endtask

  // receiver: ready drops at random per cycle
  initial begin
    forever begin
      @(negedge clk);
      res_ready = (($urandom % 100) >= recv_stall_pct);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    bus_outcome_t o;
    if (!rst && res_valid && res_ready) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("result with no request outstanding");
      end else begin
        o = outcome_q.pop_front();
        check_field("read_data", {24'd0, o.read_byte}, {24'd0, read_data});
        check_field("forward_target", {29'd0, o.target}, {29'd0, forward_target});
        check_field("forward_offset", {15'd0, o.offset}, {15'd0, forward_offset});
        check_field("forward_data", {24'd0, o.fwd_byte}, {24'd0, forward_data});
        check_field("red", {24'd0, o.red}, {24'd0, red});
        check_field("green", {24'd0, o.green}, {24'd0, green});
        check_field("blue", {24'd0, o.blue}, {24'd0, blue});
      end
    end
  end

  // watchdog on cycles with no traffic of any kind
  always @(posedge clk) begin
    if (rst || (bus_valid && bus_ready) || (res_valid && res_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    prot_cfg       = 12'd3622;
    dip_a_cfg      = 8'd255;
    dip_b_cfg      = 8'd254;
    for (int i = 0; i < 4096; i++) begin
      work_mem[i] = 8'h00;
      bg_mem[i]   = 8'h00;
    end
    for (int i = 0; i < 2048; i++) pal_mem[i] = 8'h00;

    // single reset at the start; the clearing pass runs behind req_ready
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_directed_cases();
    // protection at 0: lower mirror wraps to the top of work ram
    test_traffic(400, 0, 0, 12'd0, 8'd0, 8'd255, 1'b0);
    // protection at the top: upper mirror wraps to 0
    test_traffic(400, 68, 0, 12'd4095, 8'd255, 8'd0, 1'b0);
    test_traffic(400, 0, 68, 12'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    // lower mirror lands exactly on 0
    test_traffic(400, 8, 8, 12'd10, 8'($urandom), 8'($urandom), 1'b1);

    drain_requests();
    repeat (10) @(posedge clk);
    if (outcome_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
